### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the CAN transmit queue.
// No dependencies; each macro expands to one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

### rtl/cantxq_pkg.sv
// Package for the CAN transmit queue with mailbox: codes, field widths and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package cantxq_pkg;

  localparam int QueueDepthDefault = 64;

  localparam int IdW      = 29;
  localparam int LenW     = 4;
  localparam int PayloadW = 64;
  localparam int EntryW   = LenW + 1 + IdW + PayloadW;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_SERVICE = 2'd1;
  localparam logic [1:0] OP_TX_DONE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BUSY  = 2'd3;

  localparam logic [3:0] MAX_BYTES    = 4'd8;
  localparam logic [7:0] EXT_FLAG_BIT = 8'h08;

  typedef enum logic {
    CS_IDLE,
    CS_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic busy;
    logic out_blocked;
  } dp_status_t;

  typedef struct packed {
    logic       enqueue;
    logic       tx_done;
    logic       load_status;
    logic       load_mailbox;
    logic [1:0] status;
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/cantxq_ctrl.sv
// Controller of the CAN transmit queue: decodes the opcode and sequences a
// mailbox load. Depends on cantxq_pkg.
`default_nettype none

module cantxq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [1:0]             opcode,
  input  wire cantxq_pkg::dp_status_t sts,
  output cantxq_pkg::dp_cmd_t         cmd
);

  cantxq_pkg::ctrl_state_t state, state_next;
  logic accept;

  assign accept = (state == cantxq_pkg::CS_IDLE) && item_valid && !sts.out_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cantxq_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cantxq_pkg::CS_IDLE: begin
        if (accept && opcode == cantxq_pkg::OP_SERVICE && !sts.empty && !sts.busy) begin
          state_next = cantxq_pkg::CS_LOAD;
        end
      end
      cantxq_pkg::CS_LOAD: begin
        state_next = cantxq_pkg::CS_IDLE;
      end
      default: begin
        state_next = cantxq_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = cantxq_pkg::ST_DONE;
    item_stall = 1'b1;
    case (state)
      cantxq_pkg::CS_IDLE: begin
        item_stall = sts.out_blocked;
        if (accept) begin
          case (opcode)
            cantxq_pkg::OP_ENQUEUE: begin
              cmd.load_status = 1'b1;
              if (sts.full) begin
                cmd.status = cantxq_pkg::ST_FULL;
              end else begin
                cmd.enqueue = 1'b1;
              end
            end
            cantxq_pkg::OP_SERVICE: begin
              // The empty check comes before the busy check; a good service
              // finishes in the load state.
              if (sts.empty) begin
                cmd.load_status = 1'b1;
                cmd.status      = cantxq_pkg::ST_EMPTY;
              end else if (sts.busy) begin
                cmd.load_status = 1'b1;
                cmd.status      = cantxq_pkg::ST_BUSY;
              end
            end
            cantxq_pkg::OP_TX_DONE: begin
              cmd.load_status = 1'b1;
              cmd.tx_done     = 1'b1;
            end
            default: begin
              cmd.load_status = 1'b1;
            end
          endcase
        end
      end
      cantxq_pkg::CS_LOAD: begin
        cmd.load_mailbox = 1'b1;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/cantxq_dp.sv
// Datapath of the CAN transmit queue: frame memory, ring slots, busy mark,
// mailbox byte formatting and the result register. Depends on cantxq_pkg.
`default_nettype none

module cantxq_dp #(
  parameter int QUEUE_DEPTH = cantxq_pkg::QueueDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [cantxq_pkg::IdW-1:0]      frame_id,
  input  wire logic                          frame_ext,
  input  wire logic [cantxq_pkg::LenW-1:0]     frame_len,
  input  wire logic [cantxq_pkg::PayloadW-1:0] frame_payload,
  input  wire cantxq_pkg::dp_cmd_t           cmd,
  output cantxq_pkg::dp_status_t             sts,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [1:0]                         status,
  output logic                               sent,
  output logic [7:0]                         id_high_byte,
  output logic [7:0]                         id_low_byte,
  output logic [7:0]                         ext_high_byte,
  output logic [7:0]                         ext_low_byte,
  output logic [cantxq_pkg::LenW-1:0]          length_code,
  output logic [cantxq_pkg::PayloadW-1:0]      payload_out,
  output logic [3:0]                         payload_count,
  output logic                               mailbox_busy_flag
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);

  logic [cantxq_pkg::EntryW-1:0] queue_mem [QUEUE_DEPTH];
  logic [cantxq_pkg::EntryW-1:0] head_entry;

  logic [PtrW-1:0] write_slot, read_slot;
  logic [PtrW-1:0] write_slot_next, read_slot_next;
  logic            mailbox_busy;

  logic [cantxq_pkg::IdW-1:0]      hd_id;
  logic                          hd_ext;
  logic [cantxq_pkg::LenW-1:0]     hd_len;
  logic [cantxq_pkg::PayloadW-1:0] hd_pay;
  logic [3:0]                    hd_cnt;
  logic [cantxq_pkg::PayloadW-1:0] pay_masked;
  logic [7:0]                    fmt_id_hi, fmt_id_lo, fmt_ext_hi, fmt_ext_lo;

  assign write_slot_next = (write_slot == LastSlot) ? '0 : write_slot + PtrW'(1);
  assign read_slot_next  = (read_slot == LastSlot) ? '0 : read_slot + PtrW'(1);

  assign sts.full        = (write_slot_next == read_slot);
  assign sts.empty       = (write_slot == read_slot);
  assign sts.busy        = mailbox_busy;
  assign sts.out_blocked = result_valid && result_stall;

  // The head is read every cycle; a service transfer therefore finds the
  // head entry registered by the time the controller enters the load state.
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      queue_mem[write_slot] <= {frame_len, frame_ext, frame_id, frame_payload};
    end
    head_entry <= queue_mem[read_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      read_slot    <= '0;
      mailbox_busy <= 1'b0;
    end else begin
      if (cmd.enqueue) begin
        write_slot <= write_slot_next;
      end
      if (cmd.load_mailbox) begin
        read_slot    <= read_slot_next;
        mailbox_busy <= 1'b1;
      end else if (cmd.tx_done) begin
        mailbox_busy <= 1'b0;
      end
    end
  end

  assign {hd_len, hd_ext, hd_id, hd_pay} = head_entry;
  assign hd_cnt = (hd_len > cantxq_pkg::MAX_BYTES) ? cantxq_pkg::MAX_BYTES : hd_len;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pay_masked[i*8 +: 8] = (4'(i) < hd_cnt) ? hd_pay[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    if (hd_ext) begin
      fmt_id_hi  = hd_id[28:21];
      fmt_id_lo  = {hd_id[20:18], 3'b000, hd_id[17:16]} | cantxq_pkg::EXT_FLAG_BIT;
      fmt_ext_hi = hd_id[15:8];
      fmt_ext_lo = hd_id[7:0];
    end else begin
      fmt_id_hi  = hd_id[10:3];
      fmt_id_lo  = {hd_id[2:0], 5'b00000};
      fmt_ext_hi = 8'h00;
      fmt_ext_lo = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_status || cmd.load_mailbox) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mailbox) begin
      status            <= cantxq_pkg::ST_DONE;
      sent              <= 1'b1;
      id_high_byte      <= fmt_id_hi;
      id_low_byte       <= fmt_id_lo;
      ext_high_byte     <= fmt_ext_hi;
      ext_low_byte      <= fmt_ext_lo;
      length_code       <= hd_len;
      payload_out       <= pay_masked;
      payload_count     <= hd_cnt;
      mailbox_busy_flag <= 1'b1;
    end else if (cmd.load_status) begin
      status            <= cmd.status;
      sent              <= 1'b0;
      id_high_byte      <= '0;
      id_low_byte       <= '0;
      ext_high_byte     <= '0;
      ext_low_byte      <= '0;
      length_code       <= '0;
      payload_out       <= '0;
      payload_count     <= '0;
      mailbox_busy_flag <= cmd.tx_done ? 1'b0 : mailbox_busy;
    end
  end

endmodule

`default_nettype wire

### rtl/can_tx_frame_queue_mailbox_unit.sv
// CAN transmit frame queue with one transmit mailbox. Depends on cantxq_pkg,
// cantxq_ctrl, cantxq_dp and assert_macros.svh.
// Results: enqueue, transmit done and rejected service give their result in the
// cycle after the transfer; a service that loads the mailbox passes first through
// the load state and then the result register; the frame memory read is registered.
// Throughput: one item per cycle while the result is not blocked and outside the load state.
// Reset (synchronous, active high) empties the queue and idles the mailbox.
`default_nettype none

`include "assert_macros.svh"

module can_tx_frame_queue_mailbox_unit #(
  parameter int QUEUE_DEPTH = cantxq_pkg::QueueDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    opcode,
  input  wire logic [cantxq_pkg::IdW-1:0]      frame_id,
  input  wire logic                          frame_ext,
  input  wire logic [cantxq_pkg::LenW-1:0]     frame_len,
  input  wire logic [cantxq_pkg::PayloadW-1:0] frame_payload,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [1:0]                         status,
  output logic                               sent,
  output logic [7:0]                         id_high_byte,
  output logic [7:0]                         id_low_byte,
  output logic [7:0]                         ext_high_byte,
  output logic [7:0]                         ext_low_byte,
  output logic [cantxq_pkg::LenW-1:0]          length_code,
  output logic [cantxq_pkg::PayloadW-1:0]      payload_out,
  output logic [3:0]                         payload_count,
  output logic                               mailbox_busy_flag
);

  cantxq_pkg::dp_cmd_t    cmd;
  cantxq_pkg::dp_status_t sts;

  cantxq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .sts        (sts),
    .cmd        (cmd)
  );

  cantxq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .frame_id          (frame_id),
    .frame_ext         (frame_ext),
    .frame_len         (frame_len),
    .frame_payload     (frame_payload),
    .cmd               (cmd),
    .sts               (sts),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .status            (status),
    .sent              (sent),
    .id_high_byte      (id_high_byte),
    .id_low_byte       (id_low_byte),
    .ext_high_byte     (ext_high_byte),
    .ext_low_byte      (ext_low_byte),
    .length_code       (length_code),
    .payload_out       (payload_out),
    .payload_count     (payload_count),
    .mailbox_busy_flag (mailbox_busy_flag)
  );

  // A new item is never taken while an undelivered result blocks the register.
  `ASSERT_NEVER(a_no_overrun, clk, rst, item_valid && !item_stall && result_valid && result_stall)
  // A loaded mailbox always leaves the busy mark set.
  `ASSERT_CLK(a_sent_busy, clk, rst, (result_valid && sent) |-> mailbox_busy_flag)
  // A fresh mailbox result follows its service transfer through the load state.
  `ASSERT_CLK(a_sent_latency, clk, rst, (result_valid && sent && !$past(result_valid && result_stall)) |-> $past(item_valid && !item_stall && opcode == cantxq_pkg::OP_SERVICE, 2))
  // Results without mailbox data carry no bytes.
  `ASSERT_CLK(a_unsent_zero, clk, rst, (result_valid && !sent) |-> (payload_out == '0 && payload_count == '0 && length_code == '0))

endmodule

`default_nettype wire
